[src/ntct_pkg.sv]
// ----------------------------------------------------------------------------
// ntct_pkg
// Shared types and constants of the NTC thermostat controller.
// ----------------------------------------------------------------------------
package ntct_pkg;

	// Register map, index of each word (byte address is 4 * index)
	localparam logic [2:0] REG_TARGET  = 3'd0;
	localparam logic [2:0] REG_HYST    = 3'd1;
	localparam logic [2:0] REG_MODE    = 3'd2;
	localparam logic [2:0] REG_SUPPLY  = 3'd3;
	localparam logic [2:0] REG_SERIES  = 3'd4;
	localparam logic [2:0] REG_BETA    = 3'd5;
	localparam logic [2:0] REG_REFTEMP = 3'd6;

	// Reported thermostat state codes
	localparam logic [2:0] ST_UNDECIDED  = 3'd0;
	localparam logic [2:0] ST_HEATING    = 3'd1;
	localparam logic [2:0] ST_OVERHEATED = 3'd2;
	localparam logic [2:0] ST_FAIL       = 3'd3;
	localparam logic [2:0] ST_COOLING    = 3'd4;
	localparam logic [2:0] ST_OVERCOOLED = 3'd5;

	// Arithmetic constants
	localparam logic [18:0] FAULT_OHMS   = 19'd500000;
	localparam logic [29:0] LN2_Q30      = 30'd744261118;
	localparam int          FRAC_BITS    = 24;
	localparam logic signed [15:0] TEMP_ZERO_K = -16'sd27315;
	localparam logic signed [15:0] TEMP_MAX    = 16'sd30000;
	localparam logic signed [18:0] ZERO_C_CK   = 19'sd27315;

	// Converter settings taken from the register file
	typedef struct packed {
		logic [12:0] supply_millivolts;
		logic [19:0] series_ohms;
		logic [13:0] beta_kelvin;
		logic [15:0] ref_temp_centikelvin;
	} ntct_cfg_t;

	// Converter result
	typedef struct packed {
		logic signed [15:0] temp;
		logic               fault;
	} ntct_res_t;

endpackage

[src/ntct_in_if.sv]
// ----------------------------------------------------------------------------
// ntct_in_if
// Sample request channel: one NTC voltage in millivolts.
// ----------------------------------------------------------------------------
interface ntct_in_if;
	logic        valid;
	logic        ready;
	logic [12:0] ntc_millivolts;

	modport source(output valid, output ntc_millivolts, input ready);
	modport sink(input valid, input ntc_millivolts, output ready);
endinterface

[src/ntct_out_if.sv]
// ----------------------------------------------------------------------------
// ntct_out_if
// Result request channel: temperature, fault, state and relay drive.
// ----------------------------------------------------------------------------
interface ntct_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_centidegrees;
	logic               sensor_fault;
	logic [2:0]         control_state;
	logic               relay_on;

	modport source(output valid, output temp_centidegrees, output sensor_fault,
		output control_state, output relay_on, input ready);
	modport sink(input valid, input temp_centidegrees, input sensor_fault,
		input control_state, input relay_on, output ready);
endinterface

[src/ntct_core.sv]
// ----------------------------------------------------------------------------
// ntct_core
// Sequenced converter: fault check, two log2 squaring loops and a bit-serial
// restoring divider around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module ntct_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ntct_pkg::ntct_cfg_t cfg,
	input  logic               start,
	input  logic [12:0]        u_in,
	output logic               res_valid,
	output ntct_pkg::ntct_res_t res,
	input  logic               res_ack
);
	import ntct_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_FPROD  = 14'b00000000000010,
		S_FCMP   = 14'b00000000000100,
		S_LNINIT = 14'b00000000001000,
		S_LNSQ   = 14'b00000000010000,
		S_LNMUL  = 14'b00000000100000,
		S_LNRND  = 14'b00000001000000,
		S_B100   = 14'b00000010000000,
		S_NUM    = 14'b00000100000000,
		S_DEN1   = 14'b00001000000000,
		S_DEN2   = 14'b00010000000000,
		S_DIV    = 14'b00100000000000,
		S_FIN    = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} core_state_t;

	core_state_t        state_q;
	logic [12:0]        u_q;
	logic               second_q;
	logic [3:0]         k_q;
	logic [30:0]        m_q;
	logic [23:0]        frac_q;
	logic [4:0]         cnt_q;
	logic [63:0]        acc_q;
	logic [27:0]        lnu_q;
	logic signed [28:0] d_q;
	logic [20:0]        b100_q;
	logic [36:0]        num_q;
	logic [63:0]        rem_q;
	logic [63:0]        dsh_q;
	logic [16:0]        quo_q;
	logic               sat_q;
	logic signed [15:0] temp_q;
	logic               fault_q;

	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        mul_p;
	logic [12:0]        diff;
	logic               u_ge;
	logic [12:0]        larg;
	logic [3:0]         k_n;
	logic [30:0]        m_init;
	logic [31:0]        sq_t;
	logic [63:0]        ln_sum;
	logic [27:0]        ln_v;
	logic [27:0]        d_abs;
	logic [46:0]        den_base;
	logic [46:0]        den_prod;
	logic signed [46:0] den_n;
	logic               rem_ge;
	logic signed [18:0] tck;

	// Index of the leading one
	function automatic logic [3:0] msb_idx(input logic [12:0] v);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 13; i++) begin
			if (v[i]) r = 4'(i);
		end
		return r;
	endfunction

	assign diff   = cfg.supply_millivolts - u_q;
	assign u_ge   = (u_q >= cfg.supply_millivolts);
	assign larg   = second_q ? diff : u_q;
	assign k_n    = msb_idx(larg);
	assign m_init = {18'd0, larg} << (5'd30 - {1'b0, k_n});
	assign sq_t   = mul_p[61:30];
	assign ln_sum = acc_q + 64'(32'd1 << 29);
	assign ln_v   = ln_sum[57:30];
	assign d_abs  = d_q[28] ? 28'(-d_q) : d_q[27:0];

	// Denominator: 100*beta*2^24 + T0*d
	assign den_base = {2'b00, b100_q, 24'd0};
	assign den_prod = {3'b000, acc_q[43:0]};
	assign den_n    = d_q[28] ? $signed(den_base - den_prod) : $signed(den_base + den_prod);

	assign rem_ge = (rem_q >= dsh_q);
	assign tck    = $signed({2'b00, quo_q}) - ZERO_C_CK;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FPROD: begin
				mul_a = 32'(cfg.series_ohms);
				mul_b = 32'(u_q);
			end
			S_FCMP: begin
				mul_a = 32'(FAULT_OHMS);
				mul_b = 32'(diff);
			end
			S_LNSQ: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			S_LNMUL: begin
				mul_a = 32'({k_q, frac_q});
				mul_b = 32'(LN2_Q30);
			end
			S_B100: begin
				mul_a = 32'(cfg.beta_kelvin);
				mul_b = 32'd100;
			end
			S_NUM: begin
				mul_a = 32'(b100_q);
				mul_b = 32'(cfg.ref_temp_centikelvin);
			end
			S_DEN1: begin
				mul_a = 32'(cfg.ref_temp_centikelvin);
				mul_b = 32'(d_abs);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_FPROD;
				end
				S_FPROD: state_q <= S_FCMP;
				S_FCMP: begin
					second_q <= 1'b0;
					if (u_ge || (acc_q >= mul_p) || (u_q == '0) ||
						(cfg.beta_kelvin == '0) || (cfg.ref_temp_centikelvin == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LNINIT;
					end
				end
				S_LNINIT: begin
					cnt_q   <= '0;
					state_q <= S_LNSQ;
				end
				S_LNSQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(FRAC_BITS - 1)) state_q <= S_LNMUL;
				end
				S_LNMUL: state_q <= S_LNRND;
				S_LNRND: begin
					second_q <= 1'b1;
					state_q  <= second_q ? S_B100 : S_LNINIT;
				end
				S_B100: state_q <= S_NUM;
				S_NUM:  state_q <= S_DEN1;
				S_DEN1: state_q <= S_DEN2;
				S_DEN2: begin
					cnt_q   <= '0;
					state_q <= (den_n[46] || den_n == '0) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd17) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (res_ack) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) u_q <= u_in;
			end
			S_FPROD: acc_q <= mul_p;
			S_FCMP: begin
				fault_q <= u_ge || (acc_q >= mul_p);
				temp_q  <= TEMP_ZERO_K;
			end
			S_LNINIT: begin
				k_q    <= k_n;
				m_q    <= m_init;
				frac_q <= '0;
			end
			// One fractional log2 bit per square
			S_LNSQ: begin
				if (sq_t[31]) begin
					m_q    <= sq_t[31:1];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					m_q    <= sq_t[30:0];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			S_LNMUL: acc_q <= mul_p;
			S_LNRND: begin
				if (second_q) d_q <= $signed({1'b0, lnu_q}) - $signed({1'b0, ln_v});
				else lnu_q <= ln_v;
			end
			S_B100: b100_q <= mul_p[20:0];
			S_NUM:  num_q <= mul_p[36:0];
			S_DEN1: acc_q <= mul_p;
			S_DEN2: begin
				temp_q <= TEMP_MAX;
				rem_q  <= 64'({num_q, 24'd0}) + (64'(den_n[45:0]) >> 1);
				dsh_q  <= 64'(den_n[45:0]) << 17;
				quo_q  <= '0;
				sat_q  <= 1'b0;
			end
			// Restoring division, first step only checks for overflow
			S_DIV: begin
				if (cnt_q == '0) begin
					sat_q <= rem_ge;
				end else begin
					if (rem_ge) rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[15:0], rem_ge};
				end
				dsh_q <= dsh_q >> 1;
			end
			S_FIN: begin
				if (sat_q || tck > 19'(TEMP_MAX)) temp_q <= TEMP_MAX;
				else temp_q <= tck[15:0];
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (state_q == S_DONE);
	assign res.temp  = temp_q;
	assign res.fault = fault_q;

endmodule

[src/ntc_thermostat_controller_top.sv]
// ----------------------------------------------------------------------------
// ntc_thermostat_controller_top
// NTC divider to temperature conversion with heating/cooling hysteresis
// thermostat, APB register file and output register.
// ----------------------------------------------------------------------------
// Channel     Dir  Protocol         Payload
// sample_in   in   valid/ready      ntc_millivolts
// result_out  out  valid/ready      temp_centidegrees, sensor_fault,
//                                   control_state, relay_on
// apb         in   APB, pready = 1  7 registers at 4*index
//
// A sample that is a fault or a zero goes from the fault check straight to
// the result. The two 24-step log2 squaring loops and the 18-step divider run
// on the shared multiplier. One item is in work at a time; the next request is
// taken as soon as the result moves to the output register, even while that
// register waits for result_out.ready. No clearing after reset.
// ----------------------------------------------------------------------------
module ntc_thermostat_controller_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	ntct_in_if.sink           sample_in,
	ntct_out_if.source        result_out
);
	import ntct_pkg::*;

	logic [7:0]  target_q;
	logic [3:0]  hyst_q;
	logic        mode_q;
	logic [12:0] supply_q;
	logic [19:0] series_q;
	logic [13:0] beta_q;
	logic [15:0] reftemp_q;

	logic        busy_q;
	logic [2:0]  st_q;
	logic        out_valid_q;
	logic signed [15:0] out_temp_q;
	logic        out_fault_q;
	logic        out_relay_q;

	ntct_cfg_t   cfg;
	ntct_res_t   res;
	logic        res_valid;
	logic        accept;
	logic        move;
	logic        wr_en;
	logic [2:0]  st_n;
	logic [14:0] tgt_u;
	logic [10:0] hys_u;
	logic signed [17:0] tgt_s;
	logic signed [17:0] lo_s;
	logic signed [17:0] hi_s;
	logic signed [17:0] t_s;

	// Register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 8'd28;
			hyst_q    <= 4'd5;
			mode_q    <= 1'b0;
			supply_q  <= 13'd4750;
			series_q  <= 20'd10000;
			beta_q    <= 14'd3977;
			reftemp_q <= 16'd29815;
		end else if (wr_en) begin
			case (paddr[4:2])
				REG_TARGET:  target_q  <= pwdata[7:0];
				REG_HYST:    hyst_q    <= pwdata[3:0];
				REG_MODE:    mode_q    <= pwdata[0];
				REG_SUPPLY:  supply_q  <= pwdata[12:0];
				REG_SERIES:  series_q  <= pwdata[19:0];
				REG_BETA:    beta_q    <= pwdata[13:0];
				REG_REFTEMP: reftemp_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[4:2])
			REG_TARGET:  prdata = 32'(target_q);
			REG_HYST:    prdata = 32'(hyst_q);
			REG_MODE:    prdata = 32'(mode_q);
			REG_SUPPLY:  prdata = 32'(supply_q);
			REG_SERIES:  prdata = 32'(series_q);
			REG_BETA:    prdata = 32'(beta_q);
			REG_REFTEMP: prdata = 32'(reftemp_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg.supply_millivolts    = supply_q;
	assign cfg.series_ohms          = series_q;
	assign cfg.beta_kelvin          = beta_q;
	assign cfg.ref_temp_centikelvin = reftemp_q;

	// Handshakes
	assign sample_in.ready = !busy_q;
	assign accept = sample_in.valid && !busy_q;
	assign move   = res_valid && (!out_valid_q || result_out.ready);

	ntct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (accept),
		.u_in      (sample_in.ntc_millivolts),
		.res_valid (res_valid),
		.res       (res),
		.res_ack   (move)
	);

	// Thresholds in centidegrees
	assign tgt_u = 15'(target_q) * 15'd100;
	assign hys_u = 11'(hyst_q) * 11'd100;
	assign tgt_s = $signed({3'b000, tgt_u});
	assign lo_s  = tgt_s - $signed({7'd0, hys_u});
	assign hi_s  = tgt_s + $signed({7'd0, hys_u});
	assign t_s   = {{2{res.temp[15]}}, res.temp};

	// Thermostat next state
	always_comb begin
		st_n = st_q;
		if (!mode_q) begin
			case (st_q)
				ST_HEATING: begin
					if (res.fault) st_n = ST_FAIL;
					else if (t_s >= tgt_s) st_n = ST_OVERHEATED;
				end
				ST_OVERHEATED: begin
					if (res.fault) st_n = ST_FAIL;
					else if (t_s < lo_s) st_n = ST_HEATING;
				end
				ST_FAIL: begin
					if (!res.fault) st_n = ST_OVERHEATED;
				end
				default: st_n = ST_OVERHEATED;
			endcase
		end else begin
			case (st_q)
				ST_COOLING: begin
					if (res.fault) st_n = ST_FAIL;
					else if (t_s <= tgt_s) st_n = ST_OVERCOOLED;
				end
				ST_OVERCOOLED: begin
					if (res.fault) st_n = ST_FAIL;
					else if (t_s > hi_s) st_n = ST_COOLING;
				end
				ST_FAIL: begin
					if (!res.fault) st_n = ST_OVERCOOLED;
				end
				default: st_n = ST_OVERCOOLED;
			endcase
		end
	end

	// Control: busy flag, thermostat state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			st_q        <= ST_UNDECIDED;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) busy_q <= 1'b1;
			else if (move) busy_q <= 1'b0;
			if (move) st_q <= st_n;
			if (move) out_valid_q <= 1'b1;
			else if (result_out.ready) out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (move) begin
			out_temp_q  <= res.temp;
			out_fault_q <= res.fault;
			out_relay_q <= (st_n == ST_HEATING) || (st_n == ST_COOLING);
		end
	end

	assign result_out.valid             = out_valid_q;
	assign result_out.temp_centidegrees = out_temp_q;
	assign result_out.sensor_fault      = out_fault_q;
	assign result_out.control_state     = st_q;
	assign result_out.relay_on          = out_relay_q;

`ifndef SYNTHESIS
	a_res_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy_q)
		else $error("converter result without an item in work");

	a_fault_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_fault_q |-> out_temp_q == TEMP_ZERO_K)
		else $error("fault result with a temperature other than 0 K");

	a_relay_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_relay_q == ((st_q == ST_HEATING) || (st_q == ST_COOLING)))
		else $error("relay drive disagrees with thermostat state");

	a_move_frees: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q && !busy_q)
		else $error("result move did not load output and free the converter");
`endif

endmodule
